// ===== rtl/core/lphs_pkg.sv =====
package lphs_pkg;

  localparam int CMD_W  = 2;
  localparam int KEY_W  = 31;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 10;
  localparam int OCC_W  = 11;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [0:0] REG_LOAD_LIMIT = 1'b0;
  localparam logic [OCC_W-1:0] LOAD_LIMIT_RESET = 11'd512;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  // one table entry as stored in the slot memory
  typedef struct packed {
    logic             used;
    logic             tomb;
    logic [KEY_W-1:0] key;
  } entry_t;

endpackage

// ===== rtl/core/linear_probing_hash_set.sv =====
// Flow: a lookup, insert or delete finds its home slot (in S_HASH unless TABLE_SIZE
//   is a power of two), walks in S_PROBE, writes back in S_APPLY and gives its
//   word from S_EMIT, which an output stall holds; a clear empties every slot in S_SWEEP.
// Throughput: one command at a time, one slot read per cycle on the walk; the next
//   command is taken only after the last one has given its word.
// Reset: synchronous, active low; a clearing pass over every slot blocks input.
module linear_probing_hash_set #(
  parameter int TABLE_SIZE = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lphs_pkg::CMD_W-1:0]    in_command,
  input  logic [lphs_pkg::KEY_W-1:0]    in_key,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lphs_pkg::STAT_W-1:0]   out_status,
  output logic                          out_found,
  output logic [lphs_pkg::SLOT_W-1:0]   out_slot,
  output logic [lphs_pkg::OCC_W-1:0]    out_occupancy,
  output logic                          out_set_empty,

  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [lphs_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [lphs_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [lphs_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  import lphs_pkg::*;

  // slot index width and derived constants
  localparam int SW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam bit IS_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
  localparam logic [SW:0]   TS_W   = (SW+1)'(TABLE_SIZE);
  localparam logic [SW-1:0] LAST_IDX = SW'(TABLE_SIZE - 1);
  // home-slot reduction: 4 key bits per cycle over a 32-bit padded key
  localparam int HBITS  = 4;
  localparam int HSTEPS = 32 / HBITS;
  localparam int HCW    = $clog2(HSTEPS);
  localparam logic [HCW-1:0] HLAST = HCW'(HSTEPS - 1);

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_HASH  = 7'b0000100,
    S_PROBE = 7'b0001000,
    S_APPLY = 7'b0010000,
    S_SWEEP = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [OCC_W-1:0] load_limit_r, load_limit_nxt;
  logic             cfg_wr;

  // command in flight
  cmd_t             cmd_r, cmd_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;

  // home-slot reduction
  logic [31:0]      kshift_r, kshift_nxt;
  logic [SW-1:0]    rem_r, rem_nxt;
  logic [HCW-1:0]   hcnt_r, hcnt_nxt;
  logic [SW-1:0]    rem_step;

  // probe walk
  logic [SW-1:0]    rd_idx_r, rd_idx_nxt;
  logic [SW-1:0]    chk_idx_r, chk_idx_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [SW:0]      walked_r, walked_nxt;
  logic             hit_r, hit_nxt;
  logic [SW-1:0]    hit_idx_r, hit_idx_nxt;
  logic             has_free_r, has_free_nxt;
  logic [SW-1:0]    free_idx_r, free_idx_nxt;

  // clearing pass
  logic [SW-1:0]    sweep_r, sweep_nxt;

  // set size and pending result
  logic [OCC_W-1:0] key_total_r, key_total_nxt;
  status_t          res_status_r, res_status_nxt;
  logic             res_found_r, res_found_nxt;
  logic [SW-1:0]    res_slot_r, res_slot_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]    out_status_r, out_status_nxt;
  logic                 out_found_r, out_found_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [OCC_W-1:0]     out_occ_r, out_occ_nxt;
  logic                 out_empty_r, out_empty_nxt;
  logic [SW+SLOT_W-1:0] slot_wide;

  // slot memory
  entry_t           mem [TABLE_SIZE];
  entry_t           mem_q;
  logic             mem_re;
  logic [SW-1:0]    mem_raddr;
  logic             mem_we;
  logic [SW-1:0]    mem_waddr;
  entry_t           mem_wdata;

  logic             in_acc;
  logic             probe_stop;

  // ---------------------------------------------------------------------------
  // Configuration port: single register, always ready
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    load_limit_nxt = load_limit_r;
    if (cfg_wr && (cfg_paddr[2] == REG_LOAD_LIMIT)) begin
      load_limit_nxt = cfg_pwdata[OCC_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_LOAD_LIMIT) ?
                      {{(DATA_W-OCC_W){1'b0}}, load_limit_r} : '0;

  // ---------------------------------------------------------------------------
  // Home-slot reduction step: shift in four key bits, reduce after each
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [SW:0] t;
    logic [SW-1:0] r;
    r = rem_r;
    for (int i = 0; i < HBITS; i++) begin
      t = {r, kshift_r[31-i]};
      if (t >= TS_W) begin
        t = t - TS_W;
      end
      r = t[SW-1:0];
    end
    rem_step = r;
  end

  // ---------------------------------------------------------------------------
  // Control and datapath next state
  // ---------------------------------------------------------------------------
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    kshift_nxt     = kshift_r;
    rem_nxt        = rem_r;
    hcnt_nxt       = hcnt_r;
    rd_idx_nxt     = rd_idx_r;
    chk_idx_nxt    = chk_idx_r;
    chk_vld_nxt    = chk_vld_r;
    walked_nxt     = walked_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    has_free_nxt   = has_free_r;
    free_idx_nxt   = free_idx_r;
    sweep_nxt      = sweep_r;
    key_total_nxt  = key_total_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_slot_nxt   = res_slot_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_slot_nxt   = out_slot_r;
    out_occ_nxt    = out_occ_r;
    out_empty_nxt  = out_empty_r;
    out_valid_nxt  = out_stall ? out_valid_r : 1'b0;
    mem_re         = 1'b0;
    mem_raddr      = rd_idx_r;
    mem_we         = 1'b0;
    mem_waddr      = sweep_r;
    mem_wdata      = '0;
    probe_stop     = 1'b0;
    slot_wide      = {{SLOT_W{1'b0}}, res_slot_r};

    unique case (state_r)
      // mark every slot empty after reset, then open the input
      S_INIT: begin
        mem_we    = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt = cmd_t'(in_command);
          key_nxt = in_key;
          if (cmd_t'(in_command) == CMD_CLEAR) begin
            sweep_nxt = '0;
            state_nxt = S_SWEEP;
          end else if (IS_POW2) begin
            // home slot is the low key bits; start the walk at once
            rd_idx_nxt   = in_key[SW-1:0];
            chk_vld_nxt  = 1'b0;
            walked_nxt   = '0;
            hit_nxt      = 1'b0;
            has_free_nxt = 1'b0;
            state_nxt    = S_PROBE;
          end else begin
            kshift_nxt = {1'b0, in_key};
            rem_nxt    = '0;
            hcnt_nxt   = '0;
            state_nxt  = S_HASH;
          end
        end
      end

      S_HASH: begin
        rem_nxt    = rem_step;
        kshift_nxt = {kshift_r[31-HBITS:0], {HBITS{1'b0}}};
        hcnt_nxt   = hcnt_r + 1'b1;
        if (hcnt_r == HLAST) begin
          rd_idx_nxt   = rem_step;
          chk_vld_nxt  = 1'b0;
          walked_nxt   = '0;
          hit_nxt      = 1'b0;
          has_free_nxt = 1'b0;
          state_nxt    = S_PROBE;
        end
      end

      // Issue one slot read per cycle ahead of the check; the check looks at
      // the word read in the cycle before. Reads past the stop are dropped.
      S_PROBE: begin
        mem_re      = 1'b1;
        rd_idx_nxt  = (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + 1'b1;
        chk_idx_nxt = rd_idx_r;
        chk_vld_nxt = 1'b1;
        if (chk_vld_r) begin
          walked_nxt = walked_r + 1'b1;
          if (mem_q.used) begin
            if (mem_q.key == key_r) begin
              hit_nxt     = 1'b1;
              hit_idx_nxt = chk_idx_r;
              probe_stop  = 1'b1;
            end
          end else begin
            // first tombstone or the empty slot that ends the walk
            if (!has_free_r) begin
              has_free_nxt = 1'b1;
              free_idx_nxt = chk_idx_r;
            end
            if (!mem_q.tomb) begin
              probe_stop = 1'b1;
            end
          end
          // whole table walked without an empty slot
          if ((walked_r + 1'b1) == TS_W) begin
            probe_stop = 1'b1;
          end
        end
        if (probe_stop) begin
          state_nxt = S_APPLY;
        end
      end

      // write back the one entry the command changes and form the result
      S_APPLY: begin
        res_status_nxt = ST_OK;
        res_found_nxt  = 1'b0;
        res_slot_nxt   = '0;
        unique case (cmd_r)
          CMD_INSERT: begin
            if (hit_r) begin
              res_status_nxt = ST_DUP;
              res_found_nxt  = 1'b1;
              res_slot_nxt   = hit_idx_r;
            end else if ((key_total_r >= load_limit_r) || !has_free_r) begin
              res_status_nxt = ST_FULL;
            end else begin
              mem_we         = 1'b1;
              mem_waddr      = free_idx_r;
              mem_wdata.used = 1'b1;
              mem_wdata.tomb = 1'b0;
              mem_wdata.key  = key_r;
              key_total_nxt  = key_total_r + 1'b1;
              res_slot_nxt   = free_idx_r;
            end
          end
          CMD_LOOKUP: begin
            if (hit_r) begin
              res_found_nxt = 1'b1;
              res_slot_nxt  = hit_idx_r;
            end else begin
              res_status_nxt = ST_MISS;
            end
          end
          CMD_DELETE: begin
            if (hit_r) begin
              // leave a tombstone so later keys of the chain stay reachable
              mem_we         = 1'b1;
              mem_waddr      = hit_idx_r;
              mem_wdata.used = 1'b0;
              mem_wdata.tomb = 1'b1;
              mem_wdata.key  = key_r;
              if (key_total_r != '0) begin
                key_total_nxt = key_total_r - 1'b1;
              end
              res_found_nxt = 1'b1;
              res_slot_nxt  = hit_idx_r;
            end else begin
              res_status_nxt = ST_MISS;
            end
          end
          CMD_CLEAR: begin
            key_total_nxt = '0;
          end
          default: begin
            res_status_nxt = ST_OK;
          end
        endcase
        state_nxt = S_EMIT;
      end

      // clear command: empty every slot, one per cycle
      S_SWEEP: begin
        mem_we    = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == LAST_IDX) begin
          key_total_nxt  = '0;
          res_status_nxt = ST_OK;
          res_found_nxt  = 1'b0;
          res_slot_nxt   = '0;
          state_nxt      = S_EMIT;
        end
      end

      // hold the result until the output register is free
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_slot_nxt   = slot_wide[SLOT_W-1:0];
          out_occ_nxt    = key_total_r;
          out_empty_nxt  = (key_total_r == '0);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      sweep_r      <= '0;
      key_total_r  <= '0;
      load_limit_r <= LOAD_LIMIT_RESET;
      out_valid_r  <= 1'b0;
      chk_vld_r    <= 1'b0;
      hcnt_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      sweep_r      <= sweep_nxt;
      key_total_r  <= key_total_nxt;
      load_limit_r <= load_limit_nxt;
      out_valid_r  <= out_valid_nxt;
      chk_vld_r    <= chk_vld_nxt;
      hcnt_r       <= hcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    kshift_r     <= kshift_nxt;
    rem_r        <= rem_nxt;
    rd_idx_r     <= rd_idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    walked_r     <= walked_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    has_free_r   <= has_free_nxt;
    free_idx_r   <= free_idx_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_slot_r   <= out_slot_nxt;
    out_occ_r    <= out_occ_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  // slot memory: one read port with registered data, one write port; reads
  // happen only during the walk and writes only outside it
  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_found     = out_found_r;
  assign out_slot      = out_slot_r;
  assign out_occupancy = out_occ_r;
  assign out_set_empty = out_empty_r;

endmodule
